@@ sv/lifegrid_pkg.sv @@
package lifegrid_pkg;

    // operation codes carried in the input tuser field
    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_ADVANCE = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_SURVIVE_MIN = 2'd0;
    localparam logic [1:0] CFG_SURVIVE_MAX = 2'd1;
    localparam logic [1:0] CFG_BIRTH_MIN   = 2'd2;
    localparam logic [1:0] CFG_BIRTH_MAX   = 2'd3;

    // rule register reset values (B3/S23)
    localparam logic [3:0] RST_SURVIVE_MIN = 4'd2;
    localparam logic [3:0] RST_SURVIVE_MAX = 4'd3;
    localparam logic [3:0] RST_BIRTH_MIN   = 4'd3;
    localparam logic [3:0] RST_BIRTH_MAX   = 4'd3;

    // neighbor count ranges of the rule
    typedef struct packed {
        logic [3:0] survive_min;
        logic [3:0] survive_max;
        logic [3:0] birth_min;
        logic [3:0] birth_max;
    } t_rule;

    // sequencer states
    typedef enum logic [4:0] {
        ST_CLEAR   = 5'b00001,
        ST_IDLE    = 5'b00010,
        ST_ACCESS  = 5'b00100,
        ST_ADVANCE = 5'b01000,
        ST_REPORT  = 5'b10000
    } t_state;

endpackage

@@ sv/lifegrid_row_mem.sv @@
module lifegrid_row_mem #(
    parameter int WIDTH  = 128,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // one registered read port, data holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/lifegrid_next_row.sv @@
module lifegrid_next_row
    import lifegrid_pkg::*;
#(
    parameter int COLS = 128
) (
    input  t_rule           i_rule,
    input  logic [COLS-1:0] i_up,
    input  logic [COLS-1:0] i_mid,
    input  logic [COLS-1:0] i_down,
    output logic [COLS-1:0] o_next
);

    // dead cells beyond both edges
    logic [COLS+1:0] p_up;
    logic [COLS+1:0] p_mid;
    logic [COLS+1:0] p_down;

    assign p_up   = {1'b0, i_up, 1'b0};
    assign p_mid  = {1'b0, i_mid, 1'b0};
    assign p_down = {1'b0, i_down, 1'b0};

    // one lane per column: neighbor count and rule
    for (genvar c = 0; c < COLS; c++) begin : g_lane
        logic [3:0] count;
        logic       alive;

        assign count = 4'(p_up[c]) + 4'(p_up[c+1]) + 4'(p_up[c+2])
                     + 4'(p_mid[c]) + 4'(p_mid[c+2])
                     + 4'(p_down[c]) + 4'(p_down[c+1]) + 4'(p_down[c+2]);
        assign alive = p_mid[c+1];

        assign o_next[c] = alive
            ? ((count >= i_rule.survive_min) && (count <= i_rule.survive_max))
            : ((count >= i_rule.birth_min) && (count <= i_rule.birth_max));
    end

endmodule

@@ sv/life_cellular_automaton_grid.sv @@
// Life grid of GRID_COLUMNS x GRID_ROWS one-bit cells with configurable
// survive and birth ranges (B3/S23 after reset). The grid lives in a
// row-wide memory with one write port and one registered read port, one
// word per row. After reset a clearing pass zeroes the grid row by row
// before the first input is taken. A cell write or read reads the row,
// then extracts the cell or modifies it and writes the row back; a bad
// coordinate or unused operation skips the access state. An advance
// streams the rows through the read port once while a three-row window
// feeds the rule lanes and each new row is written back two rows behind
// the read pointer. The result register frees the input side while a
// result waits on the output.
module life_cellular_automaton_grid
    import lifegrid_pkg::*;
#(
    parameter int GRID_COLUMNS = 128,
    parameter int GRID_ROWS    = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [3:0]  i_cfg_data,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // column[7:0], row[14:8], set_value[15]
    input  logic [1:0]  s_axis_tuser,  // operation[1:0]
    // results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // read_value[0], zero fill[7:1]
    output logic        m_axis_tuser   // bad_coordinate[0]
);

    localparam int ROW_W  = (GRID_ROWS > 2) ? $clog2(GRID_ROWS) : 1;
    localparam int COL_W  = (GRID_COLUMNS > 2) ? $clog2(GRID_COLUMNS) : 1;
    localparam int STEP_W = $clog2(GRID_ROWS + 2);

    localparam logic [STEP_W-1:0] STEP_ROWS = STEP_W'(GRID_ROWS);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(GRID_ROWS + 1);
    localparam logic [STEP_W-1:0] STEP_TWO  = STEP_W'(2);

    t_state r_state, n_state;
    t_rule  r_rule;

    logic [STEP_W-1:0]       r_step, n_step;
    logic [1:0]              r_op;
    logic [COL_W-1:0]        r_col;
    logic                    r_val;
    logic [GRID_COLUMNS-1:0] r_up, r_mid;
    logic [GRID_COLUMNS-1:0] n_up, n_mid;
    logic                    r_pend_read, r_pend_bad;
    logic                    n_pend_read, n_pend_bad;
    logic                    r_m_tvalid, r_m_read, r_m_bad;

    // write address for a cell write comes from the held input row
    logic [6:0] r_row_hold;
    logic [6:0] hold_row_m1;

    // input field views
    logic [1:0] in_op;
    logic [7:0] in_col;
    logic [6:0] in_row;
    logic       in_val;
    logic [7:0] in_col_m1;
    logic [6:0] in_row_m1;
    logic       in_inside;
    logic       in_cell_op;
    logic       in_accept;

    assign in_op      = s_axis_tuser;
    assign in_col     = s_axis_tdata[7:0];
    assign in_row     = s_axis_tdata[14:8];
    assign in_val     = s_axis_tdata[15];
    assign in_col_m1  = in_col - 8'd1;
    assign in_row_m1  = in_row - 7'd1;
    assign in_inside  = (in_col >= 8'd1) && (in_col <= 8'(GRID_COLUMNS))
                     && (in_row >= 7'd1) && (in_row <= 7'(GRID_ROWS));
    assign in_cell_op = (in_op == OP_WRITE) || (in_op == OP_READ);
    assign in_accept  = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;

    // memory port signals
    logic                    mem_we, mem_re;
    logic [ROW_W-1:0]        mem_waddr, mem_raddr;
    logic [GRID_COLUMNS-1:0] mem_wdata, mem_rdata;
    logic [GRID_COLUMNS-1:0] row_mod, row_down, row_next;

    lifegrid_row_mem #(
        .WIDTH  (GRID_COLUMNS),
        .DEPTH  (GRID_ROWS),
        .ADDR_W (ROW_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // window below the row being computed, dead past the last row
    assign row_down = (r_step == STEP_LAST) ? '0 : mem_rdata;

    lifegrid_next_row #(
        .COLS (GRID_COLUMNS)
    ) u_next (
        .i_rule (r_rule),
        .i_up   (r_up),
        .i_mid  (r_mid),
        .i_down (row_down),
        .o_next (row_next)
    );

    // row with one cell replaced for a cell write
    always_comb begin
        row_mod        = mem_rdata;
        row_mod[r_col] = r_val;
    end

    // sequencer
    logic out_free;
    logic res_want, res_read, res_bad, res_load;
    logic [STEP_W-1:0] step_m2;

    assign out_free = !r_m_tvalid || m_axis_tready;
    assign step_m2  = r_step - STEP_TWO;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_up        = r_up;
        n_mid       = r_mid;
        n_pend_read = r_pend_read;
        n_pend_bad  = r_pend_bad;
        mem_we      = 1'b0;
        mem_waddr   = r_step[ROW_W-1:0];
        mem_wdata   = '0;
        mem_re      = 1'b0;
        mem_raddr   = r_step[ROW_W-1:0];
        res_want    = 1'b0;
        res_read    = 1'b0;
        res_bad     = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
                n_step = r_step + 1'b1;
                if (r_step == STEP_ROWS - 1'b1) begin
                    n_state = ST_IDLE;
                    n_step  = '0;
                end
            end
            ST_IDLE: begin
                mem_re    = s_axis_tvalid;
                mem_raddr = in_row_m1[ROW_W-1:0];
                if (in_accept) begin
                    if (in_cell_op && in_inside) begin
                        n_state = ST_ACCESS;
                    end else if (in_op == OP_ADVANCE) begin
                        n_state = ST_ADVANCE;
                        n_step  = '0;
                    end else begin
                        res_want = 1'b1;
                        res_bad  = in_cell_op;
                    end
                end
            end
            ST_ACCESS: begin
                res_want = 1'b1;
                if (r_op == OP_WRITE) begin
                    mem_we    = 1'b1;
                    mem_waddr = hold_row_m1[ROW_W-1:0];
                    mem_wdata = row_mod;
                end else begin
                    res_read = mem_rdata[r_col];
                end
            end
            ST_ADVANCE: begin
                mem_re = (r_step < STEP_ROWS);
                n_step = r_step + 1'b1;
                if (r_step == '0) begin
                    n_mid = '0;
                end else begin
                    n_up  = r_mid;
                    n_mid = mem_rdata;
                end
                if (r_step >= STEP_TWO) begin
                    mem_we    = 1'b1;
                    mem_waddr = step_m2[ROW_W-1:0];
                    mem_wdata = row_next;
                end
                if (r_step == STEP_LAST) begin
                    res_want = 1'b1;
                end
            end
            ST_REPORT: begin
                res_want = 1'b1;
                res_read = r_pend_read;
                res_bad  = r_pend_bad;
            end
            default: begin
                n_state = ST_CLEAR;
                n_step  = '0;
            end
        endcase
        // place the result, or hold it until the output register frees
        res_load = res_want && out_free;
        if (res_want) begin
            if (out_free) begin
                n_state = ST_IDLE;
            end else begin
                n_state     = ST_REPORT;
                n_pend_read = res_read;
                n_pend_bad  = res_bad;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_step     <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            if (res_load) begin
                r_m_tvalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    // rule registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rule.survive_min <= RST_SURVIVE_MIN;
            r_rule.survive_max <= RST_SURVIVE_MAX;
            r_rule.birth_min   <= RST_BIRTH_MIN;
            r_rule.birth_max   <= RST_BIRTH_MAX;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SURVIVE_MIN: r_rule.survive_min <= i_cfg_data;
                CFG_SURVIVE_MAX: r_rule.survive_max <= i_cfg_data;
                CFG_BIRTH_MIN:   r_rule.birth_min   <= i_cfg_data;
                CFG_BIRTH_MAX:   r_rule.birth_max   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_up        <= n_up;
        r_mid       <= n_mid;
        r_pend_read <= n_pend_read;
        r_pend_bad  <= n_pend_bad;
        if (in_accept) begin
            r_op       <= in_op;
            r_col      <= in_col_m1[COL_W-1:0];
            r_row_hold <= in_row;
            r_val      <= in_val;
        end
        if (res_load) begin
            r_m_read <= res_read;
            r_m_bad  <= res_bad;
        end
    end

    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = {7'd0, r_m_read};
    assign m_axis_tuser  = r_m_bad;

    // held row of the cell operation, used as the write-back address
    assign hold_row_m1 = r_row_hold - 7'd1;

    // in-bounds cell operations always pass through the access state
    a_cell_access : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && in_cell_op && in_inside |=> r_state == ST_ACCESS)
        else $error("cell operation did not reach the access state");

    // no item is taken during the clearing pass
    a_clear_block : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_CLEAR |-> !s_axis_tready)
        else $error("input accepted while clearing");

    // advance write-back never lands on the row being fetched
    a_adv_collide : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_ADVANCE && mem_we && mem_re |-> mem_waddr != mem_raddr)
        else $error("advance write collides with row read");

    // cell write-back targets the row that was read
    a_wb_row : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_ACCESS && mem_we |-> mem_waddr == hold_row_m1[ROW_W-1:0])
        else $error("cell write-back to wrong row");

endmodule
